// File: rtl/rse_pkg.sv
// Shared types and constants for the RPN stack evaluator.
package rse_pkg;

  localparam int WORD_W          = 32;
  localparam int DEF_STACK_DEPTH = 16;

  // Front-to-back queue.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  // Divider: quotient magnitude below 2^31 once the saturation check passes.
  localparam int DIV_STEPS = 31;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  localparam logic [2:0] KIND_NUM = 3'd0;
  localparam logic [2:0] KIND_ADD = 3'd1;
  localparam logic [2:0] KIND_SUB = 3'd2;
  localparam logic [2:0] KIND_MUL = 3'd3;
  localparam logic [2:0] KIND_DIV = 3'd4;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_OVERFLOW  = 3'd1;
  localparam logic [2:0] ST_UNDERFLOW = 3'd2;
  localparam logic [2:0] ST_INVALID   = 3'd3;
  localparam logic [2:0] ST_DIVZERO   = 3'd4;

  localparam logic [WORD_W-1:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [WORD_W-1:0] Q_MIN = 32'h8000_0000;

  typedef enum logic [2:0] {OP_NUM, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_BAD} op_t;

  typedef struct packed {
    op_t               op;
    logic [WORD_W-1:0] number;
    logic              last;
  } item_t;

  typedef enum logic [2:0] {BK_IDLE, BK_DEC, BK_OPR, BK_MUL, BK_DIV, BK_END} bk_state_t;

  typedef enum logic [1:0] {DV_IDLE, DV_CHK, DV_RUN, DV_FIX} dv_state_t;

endpackage

// File: rtl/rse_front.sv
// Front end: accepts words, decodes the token kind and queues them for execution.
module rse_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  input  logic [2:0]                  kind,
  input  logic signed [rse_pkg::WORD_W-1:0] number,
  input  logic                        last,
  output logic                        full,
  output logic                        q_valid,
  output rse_pkg::item_t              q_item,
  input  logic                        q_pop
);

  rse_pkg::item_t                   queue_r [rse_pkg::QUEUE_DEPTH];
  logic [rse_pkg::QPTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [rse_pkg::QPTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [rse_pkg::QCNT_W-1:0]       cnt_r, cnt_nxt;
  logic                             do_push, do_pop;
  rse_pkg::item_t                   dec_item;

  always_comb begin
    dec_item.number = number;
    dec_item.last   = last;
    case (kind)
      rse_pkg::KIND_NUM: dec_item.op = rse_pkg::OP_NUM;
      rse_pkg::KIND_ADD: dec_item.op = rse_pkg::OP_ADD;
      rse_pkg::KIND_SUB: dec_item.op = rse_pkg::OP_SUB;
      rse_pkg::KIND_MUL: dec_item.op = rse_pkg::OP_MUL;
      rse_pkg::KIND_DIV: dec_item.op = rse_pkg::OP_DIV;
      default:           dec_item.op = rse_pkg::OP_BAD;
    endcase
  end

  assign full    = (cnt_r == rse_pkg::QCNT_W'(rse_pkg::QUEUE_DEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_item  = queue_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + rse_pkg::QCNT_W'(do_push) - rse_pkg::QCNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      queue_r[wr_ptr_r] <= dec_item;
    end
  end

endmodule

// File: rtl/rse_div.sv
// Iterative signed Q16.16 divider, one quotient bit per cycle, saturating.
module rse_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [rse_pkg::WORD_W-1:0]  dividend,
  input  logic [rse_pkg::WORD_W-1:0]  divisor,
  output logic                        done,
  output logic [rse_pkg::WORD_W-1:0]  quotient
);

  rse_pkg::dv_state_t               state_r, state_nxt;
  logic                             neg_r, neg_nxt;
  logic                             sat_r, sat_nxt;
  logic [31:0]                      mag_a_r, mag_a_nxt;
  logic [31:0]                      mag_b_r, mag_b_nxt;
  logic [31:0]                      rem_r, rem_nxt;
  logic [30:0]                      bits_r, bits_nxt;
  logic [30:0]                      quo_r, quo_nxt;
  logic [rse_pkg::DIV_CNT_W-1:0]    step_r, step_nxt;
  logic [32:0]                      trial;
  logic [33:0]                      diff;
  logic                             ge;
  logic [31:0]                      quo_ext;

  assign trial   = {rem_r, bits_r[30]};
  assign diff    = {1'b0, trial} - {2'b00, mag_b_r};
  assign ge      = !diff[33];
  assign quo_ext = {1'b0, quo_r};

  always_comb begin
    state_nxt = state_r;
    neg_nxt   = neg_r;
    sat_nxt   = sat_r;
    mag_a_nxt = mag_a_r;
    mag_b_nxt = mag_b_r;
    rem_nxt   = rem_r;
    bits_nxt  = bits_r;
    quo_nxt   = quo_r;
    step_nxt  = step_r;
    done      = 1'b0;
    quotient  = '0;
    case (state_r)
      rse_pkg::DV_IDLE: begin
        if (start) begin
          neg_nxt   = dividend[31] ^ divisor[31];
          mag_a_nxt = dividend[31] ? 32'(-dividend) : dividend;
          mag_b_nxt = divisor[31]  ? 32'(-divisor)  : divisor;
          state_nxt = rse_pkg::DV_CHK;
        end
      end
      rse_pkg::DV_CHK: begin
        // |a| * 2^16 / |b| >= 2^31 exactly when |a| >= |b| * 2^15
        if ({15'd0, mag_a_r} >= {mag_b_r, 15'd0}) begin
          sat_nxt   = 1'b1;
          state_nxt = rse_pkg::DV_FIX;
        end else begin
          sat_nxt   = 1'b0;
          rem_nxt   = {15'd0, mag_a_r[31:15]};
          bits_nxt  = {mag_a_r[14:0], 16'd0};
          quo_nxt   = '0;
          step_nxt  = rse_pkg::DIV_CNT_W'(rse_pkg::DIV_STEPS);
          state_nxt = rse_pkg::DV_RUN;
        end
      end
      rse_pkg::DV_RUN: begin
        rem_nxt  = ge ? diff[31:0] : trial[31:0];
        quo_nxt  = {quo_r[29:0], ge};
        bits_nxt = {bits_r[29:0], 1'b0};
        step_nxt = step_r - 1'b1;
        if (step_r == rse_pkg::DIV_CNT_W'(1)) begin
          state_nxt = rse_pkg::DV_FIX;
        end
      end
      rse_pkg::DV_FIX: begin
        done = 1'b1;
        if (sat_r) begin
          quotient = neg_r ? rse_pkg::Q_MIN : rse_pkg::Q_MAX;
        end else begin
          quotient = neg_r ? 32'(-quo_ext) : quo_ext;
        end
        state_nxt = rse_pkg::DV_IDLE;
      end
      default: state_nxt = rse_pkg::DV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rse_pkg::DV_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r   <= neg_nxt;
    sat_r   <= sat_nxt;
    mag_a_r <= mag_a_nxt;
    mag_b_r <= mag_b_nxt;
    rem_r   <= rem_nxt;
    bits_r  <= bits_nxt;
    quo_r   <= quo_nxt;
    step_r  <= step_nxt;
  end

endmodule

// File: rtl/rse_back.sv
// Back end: operand stack, arithmetic, error latch and result register.
module rse_back #(
  parameter int STACK_DEPTH = rse_pkg::DEF_STACK_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid,
  input  rse_pkg::item_t              q_item,
  output logic                        q_pop,
  output logic                        out_empty,
  input  logic                        out_pop,
  output logic [2:0]                  out_status,
  output logic [rse_pkg::WORD_W-1:0]  out_answer
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic [rse_pkg::WORD_W-1:0]       stk_mem [STACK_DEPTH];

  rse_pkg::bk_state_t               state_r, state_nxt;
  rse_pkg::item_t                   item_r, item_nxt;
  logic [CW-1:0]                    cnt_r, cnt_nxt;
  logic [2:0]                       err_r, err_nxt;
  logic [rse_pkg::WORD_W-1:0]       tos_r, tos_nxt;
  logic [rse_pkg::WORD_W-1:0]       rd_r;
  logic signed [63:0]               prod_r;
  logic                             out_valid_r, out_valid_nxt;
  logic [2:0]                       status_r, status_nxt;
  logic [rse_pkg::WORD_W-1:0]       answer_r, answer_nxt;

  logic                             wr_en, rd_en, prod_en;
  logic [AW-1:0]                    wr_addr;
  logic [rse_pkg::WORD_W-1:0]       wr_data;
  logic [CW-1:0]                    cnt_m1, cnt_m2;
  logic [32:0]                      sum_w, dif_w;
  logic [63:0]                      rnd_w;
  logic [47:0]                      q48;
  logic [rse_pkg::WORD_W-1:0]       mul_res;
  logic                             div_start, div_done;
  logic [rse_pkg::WORD_W-1:0]       div_quo;

  function automatic logic [31:0] sat33(input logic [32:0] s);
    if (s[32] != s[31]) begin
      sat33 = s[32] ? rse_pkg::Q_MIN : rse_pkg::Q_MAX;
    end else begin
      sat33 = s[31:0];
    end
  endfunction

  rse_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (rd_r),
    .divisor  (tos_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  // rd_r holds the value under the top (a), tos_r the top (b)
  assign cnt_m1 = cnt_r - 1'b1;
  assign cnt_m2 = cnt_r - CW'(2);
  assign sum_w  = {rd_r[31], rd_r} + {tos_r[31], tos_r};
  assign dif_w  = {rd_r[31], rd_r} - {tos_r[31], tos_r};

  // round half away from zero: bias 0x8000 for positive, 0x7FFF for negative
  assign rnd_w = $unsigned(prod_r) + (prod_r[63] ? 64'd32767 : 64'd32768);
  assign q48   = rnd_w[63:16];
  always_comb begin
    if ((&q48[47:31]) || !(|q48[47:31])) begin
      mul_res = q48[31:0];
    end else begin
      mul_res = q48[47] ? rse_pkg::Q_MIN : rse_pkg::Q_MAX;
    end
  end

  assign out_empty  = !out_valid_r;
  assign out_status = status_r;
  assign out_answer = answer_r;

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    cnt_nxt       = cnt_r;
    err_nxt       = err_r;
    tos_nxt       = tos_r;
    out_valid_nxt = out_valid_r;
    status_nxt    = status_r;
    answer_nxt    = answer_r;
    q_pop         = 1'b0;
    wr_en         = 1'b0;
    wr_addr       = cnt_m2[AW-1:0];
    wr_data       = tos_r;
    rd_en         = 1'b0;
    prod_en       = 1'b0;
    div_start     = 1'b0;

    if (out_pop && out_valid_r) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      rse_pkg::BK_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          item_nxt  = q_item;
          state_nxt = rse_pkg::BK_DEC;
        end
      end
      rse_pkg::BK_DEC: begin
        state_nxt = rse_pkg::BK_END;
        if (err_r == rse_pkg::ST_OK) begin
          case (item_r.op)
            rse_pkg::OP_NUM: begin
              if (cnt_r == CW'(STACK_DEPTH)) begin
                err_nxt = rse_pkg::ST_OVERFLOW;
              end else begin
                wr_en   = 1'b1;
                wr_addr = cnt_r[AW-1:0];
                wr_data = item_r.number;
                tos_nxt = item_r.number;
                cnt_nxt = cnt_r + 1'b1;
              end
            end
            rse_pkg::OP_ADD, rse_pkg::OP_SUB, rse_pkg::OP_MUL, rse_pkg::OP_DIV: begin
              if (cnt_r < CW'(2)) begin
                err_nxt = rse_pkg::ST_UNDERFLOW;
              end else begin
                rd_en     = 1'b1;
                state_nxt = rse_pkg::BK_OPR;
              end
            end
            default: err_nxt = rse_pkg::ST_INVALID;
          endcase
        end
      end
      rse_pkg::BK_OPR: begin
        state_nxt = rse_pkg::BK_END;
        case (item_r.op)
          rse_pkg::OP_ADD: begin
            wr_en   = 1'b1;
            wr_data = sat33(sum_w);
            tos_nxt = sat33(sum_w);
            cnt_nxt = cnt_m1;
          end
          rse_pkg::OP_SUB: begin
            wr_en   = 1'b1;
            wr_data = sat33(dif_w);
            tos_nxt = sat33(dif_w);
            cnt_nxt = cnt_m1;
          end
          rse_pkg::OP_MUL: begin
            prod_en   = 1'b1;
            state_nxt = rse_pkg::BK_MUL;
          end
          rse_pkg::OP_DIV: begin
            if (tos_r == '0) begin
              err_nxt = rse_pkg::ST_DIVZERO;
            end else begin
              div_start = 1'b1;
              state_nxt = rse_pkg::BK_DIV;
            end
          end
          default: state_nxt = rse_pkg::BK_END;
        endcase
      end
      rse_pkg::BK_MUL: begin
        wr_en     = 1'b1;
        wr_data   = mul_res;
        tos_nxt   = mul_res;
        cnt_nxt   = cnt_m1;
        state_nxt = rse_pkg::BK_END;
      end
      rse_pkg::BK_DIV: begin
        if (div_done) begin
          wr_en     = 1'b1;
          wr_data   = div_quo;
          tos_nxt   = div_quo;
          cnt_nxt   = cnt_m1;
          state_nxt = rse_pkg::BK_END;
        end
      end
      rse_pkg::BK_END: begin
        if (!item_r.last) begin
          state_nxt = rse_pkg::BK_IDLE;
        end else if (!out_valid_r || out_pop) begin
          out_valid_nxt = 1'b1;
          status_nxt    = err_r;
          answer_nxt    = (err_r == rse_pkg::ST_OK && cnt_r != '0) ? tos_r : '0;
          cnt_nxt       = '0;
          err_nxt       = rse_pkg::ST_OK;
          state_nxt     = rse_pkg::BK_IDLE;
        end
      end
      default: state_nxt = rse_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rse_pkg::BK_IDLE;
      cnt_r       <= '0;
      err_r       <= rse_pkg::ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r   <= item_nxt;
    tos_r    <= tos_nxt;
    status_r <= status_nxt;
    answer_r <= answer_nxt;
    if (prod_en) begin
      prod_r <= $signed(rd_r) * $signed(tos_r);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      stk_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_r <= stk_mem[cnt_m2[AW-1:0]];
    end
  end

endmodule

// File: rtl/rpn_stack_evaluator.sv
// Top level of the RPN stack evaluator.
// Evaluates reverse Polish expressions in signed Q16.16, one token word at a
// time; a word marked last yields one result word (status, top of stack) and
// clears the stack and the error latch. A four-word queue in the front end
// takes tokens while the execution unit works, so in_full rises only after
// four words pile up behind a busy operation. In the execution unit each
// token passes the idle, decode and end states; add and subtract add the
// operate state, multiply the operate and multiply states, and divide waits
// on the 31-step shift-subtract quotient loop; a last word holds the end
// state until the prior result is popped. The operand stack, a memory of
// STACK_DEPTH words, has no clearing pass; the block is ready after reset.
module rpn_stack_evaluator #(
  parameter int STACK_DEPTH = rse_pkg::DEF_STACK_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_push,
  output logic                              in_full,
  input  logic [2:0]                        in_kind,
  input  logic signed [rse_pkg::WORD_W-1:0] in_number,
  input  logic                              in_last,
  output logic                              out_empty,
  input  logic                              out_pop,
  output logic [2:0]                        out_status,
  output logic signed [rse_pkg::WORD_W-1:0] out_answer
);

  logic                       q_valid;
  logic                       q_pop;
  rse_pkg::item_t             q_item;
  logic [rse_pkg::WORD_W-1:0] answer;

  rse_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (in_push),
    .kind    (in_kind),
    .number  (in_number),
    .last    (in_last),
    .full    (in_full),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  rse_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_status (out_status),
    .out_answer (answer)
  );

  assign out_answer = $signed(answer);

endmodule

// File: rtl/rse_checker.sv
// Port-level checks for the RPN stack evaluator, bound to the top level.
module rse_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_push,
  input logic                              in_full,
  input logic                              in_last,
  input logic                              out_empty,
  input logic                              out_pop,
  input logic [2:0]                        out_status,
  input logic signed [rse_pkg::WORD_W-1:0] out_answer
);

  // last words accepted but not yet popped as results
  logic [3:0] pending_r, pending_nxt;
  logic       last_in, res_out;

  assign last_in = in_push && !in_full && in_last;
  assign res_out = out_pop && !out_empty;

  always_comb begin
    pending_nxt = pending_r + 4'(last_in) - 4'(res_out);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_nxt;
    end
  end

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> (out_empty && !in_full))
    else $error("queues not empty after reset");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=>
      (!out_empty && $stable(out_status) && $stable(out_answer)))
    else $error("stalled result word changed");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_status != rse_pkg::ST_OK) |-> (out_answer == '0))
    else $error("nonzero answer with error status");

  a_result_caused: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (pending_r != '0))
    else $error("result word without a last token");

endmodule

bind rpn_stack_evaluator rse_checker u_rse_checker (.*);
